@@ sv/double_stack_shared_array_defines.svh @@
//------------------------------------------------------------------------------
// Double stack shared array: assertion macros
// Concurrent check helpers used by the top level, the one file that carries assertions.
//------------------------------------------------------------------------------
`ifndef DOUBLE_STACK_SHARED_ARRAY_DEFINES_SVH
`define DOUBLE_STACK_SHARED_ARRAY_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled in reset
`define DSSA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset
`define DSSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define DSSA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define DSSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ sv/dssa_pkg.sv @@
//------------------------------------------------------------------------------
// Double stack shared array: package
// Sizes, codes, word types and controller/datapath buses.
//------------------------------------------------------------------------------
package dssa_pkg;

    // Store geometry
    localparam int DEPTH   = 64;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);

    // Fixed field widths
    localparam int SIZE_W  = 7;
    localparam int CMD_W   = 3;
    localparam int POS_W   = 6;
    localparam int DATA_W  = 32;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);

    // Register index, taken from paddr above the byte offset
    localparam logic REG_ARRAY_SIZE = 1'b0;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUSH    = CMD_W'(0);
    localparam logic [CMD_W-1:0] CMD_POP     = CMD_W'(1);
    localparam logic [CMD_W-1:0] CMD_PEEK    = CMD_W'(2);
    localparam logic [CMD_W-1:0] CMD_MODIFY  = CMD_W'(3);
    localparam logic [CMD_W-1:0] CMD_DISPLAY = CMD_W'(4);

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_BADPOS   = 2'd3
    } t_status;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic                     which_stack;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } t_in_word;

    typedef struct packed {
        t_status                  status;
        logic signed [DATA_W-1:0] data;
        logic                     last;
    } t_out_word;

    typedef enum logic {
        S_IDLE,
        S_EMIT
    } t_state;

    typedef enum logic {
        WR_PUSH,
        WR_MOD
    } t_wr_kind;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_PUSH,
        CNT_POP
    } t_cnt_op;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_TOP,
        RD_ALL,
        RD_NEXT
    } t_rd_op;

    // Commands from controller to datapath
    typedef struct packed {
        logic     wr_en;
        t_wr_kind wr_kind;
        t_cnt_op  cnt_op;
        t_rd_op   rd_op;
        logic     out_imm;
        t_status  imm_status;
        logic     out_mem;
    } t_ctl;

    // Status from datapath to controller
    typedef struct packed {
        logic full;
        logic sel_empty;
        logic pos_ok;
        logic walk_last;
        logic out_free;
    } t_stat;

    // Map a written size onto 1..DEPTH
    function automatic logic [CNT_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        logic [CNT_W-1:0] res;
        if (v == '0) begin
            res = CNT_W'(1);
        end else if (v > SIZE_W'(DEPTH)) begin
            res = CNT_W'(DEPTH);
        end else begin
            res = CNT_W'(v);
        end
        return res;
    endfunction

endpackage

@@ sv/double_stack_shared_array.sv @@
//------------------------------------------------------------------------------
// Double stack shared array: top level
// Two stacks in one word store, driven by a command stream, sized over APB.
//------------------------------------------------------------------------------
// Two stacks share a 64-word store: the lower stack grows up from entry 0, the
// upper stack grows down from entry array_size-1. Commands arrive one word at
// a time; push, modify and a failing command load their result directly, an
// unknown command gives none, pop and peek read the top entry first, and a
// display of N entries gives one result word per cycle while the output is
// not stalled, as every word read goes through the single registered read port
// of the store. A new command is taken only once the previous one has handed
// its last result to the output register. Writing array_size (address 0)
// empties both stacks; the store contents are kept. Results wait in an output
// register, so a stalled consumer only holds the block, nothing is lost.
`include "double_stack_shared_array_defines.svh"

module double_stack_shared_array (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  dssa_pkg::t_in_word             i_in_word,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output dssa_pkg::t_out_word            o_out_word,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dssa_pkg::PADDR_W-1:0]   paddr,
    input  logic [dssa_pkg::PDATA_W-1:0]   pwdata,
    output logic [dssa_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);
    import dssa_pkg::*;

    t_ctl  w_ctl;
    t_stat w_stat;

    assign pready = 1'b1;

    // Command sequencing
    dssa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_in_word.cmd),
        .i_stat     (w_stat),
        .o_in_ready (o_in_ready),
        .o_ctl      (w_ctl)
    );

    // Store and pointers
    dssa_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_ctl       (w_ctl),
        .o_stat      (w_stat),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata)
    );

    // Checks
    `DSSA_ASSERT_IMPL(a_ready_needs_slot, i_clk, i_rst_n, o_in_ready, !o_out_valid || i_out_ready, "input ready while result register is blocked")
    `DSSA_ASSERT_IMPL(a_single_load, i_clk, i_rst_n, w_ctl.out_imm, !w_ctl.out_mem, "two result loads in one cycle")
    `DSSA_ASSERT_IMPL(a_no_rw_clash, i_clk, i_rst_n, w_ctl.wr_en, w_ctl.rd_op == RD_NONE, "store write and read in one cycle")
    `DSSA_ASSERT_NEXT(a_busy_after_read, i_clk, i_rst_n, w_ctl.rd_op == RD_TOP || w_ctl.rd_op == RD_ALL, !o_in_ready, "new word taken while a read is in flight")

endmodule

@@ sv/dssa_ctrl.sv @@
//------------------------------------------------------------------------------
// Double stack shared array: controller
// Decodes each accepted command and sequences store reads and result words.
//------------------------------------------------------------------------------
module dssa_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic [dssa_pkg::CMD_W-1:0]   i_cmd,
    input  dssa_pkg::t_stat              i_stat,
    output logic                         o_in_ready,
    output dssa_pkg::t_ctl               o_ctl
);
    import dssa_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign w_accept = (r_state == S_IDLE) && i_in_valid && i_stat.out_free;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && !i_stat.sel_empty &&
                    (i_cmd == CMD_POP || i_cmd == CMD_PEEK || i_cmd == CMD_DISPLAY)) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free && i_stat.walk_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready       = 1'b0;
        o_ctl.wr_en      = 1'b0;
        o_ctl.wr_kind    = WR_PUSH;
        o_ctl.cnt_op     = CNT_HOLD;
        o_ctl.rd_op      = RD_NONE;
        o_ctl.out_imm    = 1'b0;
        o_ctl.imm_status = ST_OK;
        o_ctl.out_mem    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = i_stat.out_free;
                if (w_accept) begin
                    case (i_cmd) inside
                        CMD_PUSH: begin
                            o_ctl.out_imm = 1'b1;
                            if (i_stat.full) begin
                                o_ctl.imm_status = ST_OVERFLOW;
                            end else begin
                                o_ctl.wr_en  = 1'b1;
                                o_ctl.cnt_op = CNT_PUSH;
                            end
                        end
                        CMD_POP, CMD_PEEK: begin
                            if (i_stat.sel_empty) begin
                                o_ctl.out_imm    = 1'b1;
                                o_ctl.imm_status = ST_EMPTY;
                            end else begin
                                o_ctl.rd_op = RD_TOP;
                                if (i_cmd == CMD_POP) begin
                                    o_ctl.cnt_op = CNT_POP;
                                end
                            end
                        end
                        CMD_MODIFY: begin
                            o_ctl.out_imm = 1'b1;
                            if (i_stat.pos_ok) begin
                                o_ctl.wr_en   = 1'b1;
                                o_ctl.wr_kind = WR_MOD;
                            end else begin
                                o_ctl.imm_status = ST_BADPOS;
                            end
                        end
                        CMD_DISPLAY: begin
                            if (i_stat.sel_empty) begin
                                o_ctl.out_imm    = 1'b1;
                                o_ctl.imm_status = ST_EMPTY;
                            end else begin
                                o_ctl.rd_op = RD_ALL;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_EMIT: begin
                // When the output is free, send the word in the read register and fetch the next one
                if (i_stat.out_free) begin
                    o_ctl.out_mem = 1'b1;
                    if (!i_stat.walk_last) begin
                        o_ctl.rd_op = RD_NEXT;
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

@@ sv/dssa_dp.sv @@
//------------------------------------------------------------------------------
// Double stack shared array: datapath
// Word store, stack pointers, size register, walk pointer and result register.
//------------------------------------------------------------------------------
module dssa_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  dssa_pkg::t_in_word             i_in_word,
    input  dssa_pkg::t_ctl                 i_ctl,
    output dssa_pkg::t_stat                o_stat,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output dssa_pkg::t_out_word            o_out_word,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dssa_pkg::PADDR_W-1:0]   paddr,
    input  logic [dssa_pkg::PDATA_W-1:0]   pwdata,
    output logic [dssa_pkg::PDATA_W-1:0]   prdata
);
    import dssa_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    logic [CNT_W-1:0]  r_size, n_size;
    logic [CNT_W-1:0]  r_low, n_low;
    logic [CNT_W-1:0]  r_upb, n_upb;

    logic [ADDR_W-1:0] r_ptr, n_ptr;
    logic [CNT_W-1:0]  r_left, n_left;
    logic              r_dir, n_dir;

    logic              r_out_valid;
    t_out_word         r_out;

    logic              w_upper;
    logic              w_cfg_wr;
    logic [CNT_W-1:0]  w_new_size;
    logic [SIZE_W-1:0] w_pos;
    logic              w_low_empty;
    logic              w_up_empty;
    logic [ADDR_W-1:0] w_low_top;
    logic [ADDR_W-1:0] w_up_top;
    logic [ADDR_W-1:0] w_start;
    logic [CNT_W-1:0]  w_start_cnt;
    logic [ADDR_W-1:0] w_wr_addr;
    logic [ADDR_W-1:0] w_rd_addr;
    logic              w_rd_en;
    logic              w_out_free;

    assign w_upper    = i_in_word.which_stack;
    assign w_cfg_wr   = psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_ARRAY_SIZE);
    assign w_new_size = clamp_size(pwdata[SIZE_W-1:0]);
    assign w_pos      = SIZE_W'(i_in_word.position);

    // Stack status
    assign w_low_empty = (r_low == '0);
    assign w_up_empty  = (r_upb >= r_size);
    assign w_out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        o_stat.full      = (r_low >= r_upb);
        o_stat.sel_empty = w_upper ? w_up_empty : w_low_empty;
        o_stat.pos_ok    = w_upper ?
                           ((w_pos >= SIZE_W'(r_upb)) && (w_pos < SIZE_W'(r_size))) :
                           (w_pos < SIZE_W'(r_low));
        o_stat.walk_last = (r_left == CNT_W'(1));
        o_stat.out_free  = w_out_free;
    end

    // Store addresses
    assign w_low_top   = ADDR_W'(r_low - CNT_W'(1));
    assign w_up_top    = ADDR_W'(r_upb);
    assign w_start     = w_upper ? w_up_top : w_low_top;
    assign w_start_cnt = (i_ctl.rd_op == RD_TOP) ? CNT_W'(1) :
                         (w_upper ? CNT_W'(r_size - r_upb) : r_low);

    always_comb begin
        if (i_ctl.wr_kind == WR_MOD) begin
            w_wr_addr = ADDR_W'(i_in_word.position);
        end else if (w_upper) begin
            w_wr_addr = ADDR_W'(r_upb - CNT_W'(1));
        end else begin
            w_wr_addr = ADDR_W'(r_low);
        end
    end

    assign w_rd_en   = (i_ctl.rd_op != RD_NONE);
    assign w_rd_addr = (i_ctl.rd_op == RD_NEXT) ? r_ptr : w_start;

    // Size and stack pointers
    always_comb begin
        n_size = r_size;
        n_low  = r_low;
        n_upb  = r_upb;
        if (w_cfg_wr) begin
            n_size = w_new_size;
            n_low  = '0;
            n_upb  = w_new_size;
        end else begin
            case (i_ctl.cnt_op)
                CNT_PUSH: begin
                    if (w_upper) begin
                        n_upb = r_upb - CNT_W'(1);
                    end else begin
                        n_low = r_low + CNT_W'(1);
                    end
                end
                CNT_POP: begin
                    if (w_upper) begin
                        n_upb = r_upb + CNT_W'(1);
                    end else begin
                        n_low = r_low - CNT_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // Walk pointer: upper stack lists upward, lower stack downward
    always_comb begin
        n_ptr  = r_ptr;
        n_left = r_left;
        n_dir  = r_dir;
        case (i_ctl.rd_op)
            RD_TOP, RD_ALL: begin
                n_dir  = w_upper;
                n_ptr  = w_upper ? (w_start + ADDR_W'(1)) : (w_start - ADDR_W'(1));
                n_left = w_start_cnt;
            end
            RD_NEXT: begin
                n_ptr  = r_dir ? (r_ptr + ADDR_W'(1)) : (r_ptr - ADDR_W'(1));
                n_left = r_left - CNT_W'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= clamp_size(SIZE_RESET);
            r_low  <= '0;
            r_upb  <= clamp_size(SIZE_RESET);
            r_ptr  <= '0;
            r_left <= '0;
            r_dir  <= 1'b0;
        end else begin
            r_size <= n_size;
            r_low  <= n_low;
            r_upb  <= n_upb;
            r_ptr  <= n_ptr;
            r_left <= n_left;
            r_dir  <= n_dir;
        end
    end

    // Word store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[w_wr_addr] <= i_in_word.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.out_imm || i_ctl.out_mem) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_imm) begin
            r_out.status <= i_ctl.imm_status;
            r_out.data   <= '0;
            r_out.last   <= 1'b1;
        end else if (i_ctl.out_mem) begin
            r_out.status <= ST_OK;
            r_out.data   <= r_rd_data;
            r_out.last   <= o_stat.walk_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // Register readback
    assign prdata = (paddr[PADDR_W-1:2] == REG_ARRAY_SIZE) ? PDATA_W'(r_size) : '0;

endmodule
